// ----- hdl/vkd_pkg.sv -----
// vkd_pkg: shared types, character constants and key codes of the vt100 key decoder
// no dependencies; used by every file in hdl but vkd_channels
`default_nettype none

package vkd_pkg;

    localparam int MAX_CSI_BYTES = 15;
    localparam int CSI_LEN_W     = $clog2(MAX_CSI_BYTES + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_WAIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_WAIT = 1'b1;

    localparam logic [7:0] ESC_WAIT_RESET  = 8'd10;
    localparam logic [7:0] IDLE_WAIT_RESET = 8'd40;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_FINAL_LO = 8'h40;
    localparam logic [7:0] CH_FINAL_HI = 8'h7E;
    localparam logic [7:0] CH_CSI      = 8'h5B;
    localparam logic [7:0] CH_SS3      = 8'h4F;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_1        = 8'h31;
    localparam logic [7:0] CH_3        = 8'h33;
    localparam logic [7:0] CH_4        = 8'h34;
    localparam logic [7:0] CH_5        = 8'h35;
    localparam logic [7:0] CH_6        = 8'h36;
    localparam logic [7:0] CH_A        = 8'h41;
    localparam logic [7:0] CH_B        = 8'h42;
    localparam logic [7:0] CH_C        = 8'h43;
    localparam logic [7:0] CH_D        = 8'h44;
    localparam logic [7:0] CH_F        = 8'h46;
    localparam logic [7:0] CH_H        = 8'h48;
    localparam logic [7:0] CH_P        = 8'h50;

    typedef enum logic [3:0] {
        KEY_PLAIN     = 4'd0,
        KEY_TIMEOUT   = 4'd1,
        KEY_BACKSPACE = 4'd2,
        KEY_ESC       = 4'd3,
        KEY_UP        = 4'd4,
        KEY_DOWN      = 4'd5,
        KEY_RIGHT     = 4'd6,
        KEY_LEFT      = 4'd7,
        KEY_HOME      = 4'd8,
        KEY_END       = 4'd9,
        KEY_DELETE    = 4'd10,
        KEY_PGUP      = 4'd11,
        KEY_PGDN      = 4'd12,
        KEY_F1        = 4'd13,
        KEY_F5        = 4'd14
    } key_kind_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        key_kind_t  kind;
        logic [7:0] code;
    } key_t;

    // result of one parser step
    typedef struct packed {
        logic fire;
        key_t key;
    } step_out_t;

    // letter finals shared by CSI and SS3; P is F1 only after SS3
    function automatic key_kind_t letter_key(input logic [7:0] b, input logic ss3);
        key_kind_t k;
        case (b)
            CH_A:    k = KEY_UP;
            CH_B:    k = KEY_DOWN;
            CH_C:    k = KEY_RIGHT;
            CH_D:    k = KEY_LEFT;
            CH_H:    k = KEY_HOME;
            CH_F:    k = KEY_END;
            CH_P:    k = ss3 ? KEY_F1 : KEY_ESC;
            default: k = KEY_ESC;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/vkd_channels.sv -----
// vkd_channels: valid/ready channel interfaces for terminal input and key output
// no dependencies
`default_nettype none

interface vkd_byte_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] byte_value;

    modport source (output valid, output operation, output byte_value, input ready);
    modport sink   (input valid, input operation, input byte_value, output ready);
endinterface

interface vkd_key_if;
    logic       valid;
    logic       ready;
    logic [3:0] key_kind;
    logic [7:0] char_code;

    modport source (output valid, output key_kind, output char_code, input ready);
    modport sink   (input valid, input key_kind, input char_code, output ready);
endinterface

`default_nettype wire

// ----- hdl/vkd_parser.sv -----
// vkd_parser: escape sequence state and one-step decode of a registered word
// depends on vkd_pkg
`default_nettype none

module vkd_parser
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire vkd_pkg::item_t    item,
    input  wire logic [7:0]        esc_wait,
    input  wire logic [7:0]        idle_wait,
    output vkd_pkg::step_out_t     result
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ESC,
        MODE_SS3,
        MODE_CSI
    } mode_t;

    mode_t                            mode_reg, mode_next;
    logic [7:0]                       wait_reg, wait_next;
    logic [vkd_pkg::CSI_LEN_W-1:0]    len_reg, len_next;
    logic [7:0]                       first_reg, first_next;
    logic [7:0]                       second_reg, second_next;

    logic [7:0]                       wait_inc;
    logic [7:0]                       limit;
    logic [vkd_pkg::CSI_LEN_W-1:0]    len;
    logic                             is_final;
    vkd_pkg::key_kind_t               csi_kind;
    logic [7:0]                       b;

    always_comb
    begin
        b        = item.byte_value;
        wait_inc = (wait_reg == 8'hFF) ? wait_reg : wait_reg + 8'd1;
        limit    = (mode_reg == MODE_IDLE) ? idle_wait : esc_wait;
        len      = len_reg + vkd_pkg::CSI_LEN_W'(1);
        is_final = b inside {[vkd_pkg::CH_FINAL_LO:vkd_pkg::CH_FINAL_HI]};

        // body length counts the final byte
        if (len == vkd_pkg::CSI_LEN_W'(1))
            csi_kind = vkd_pkg::letter_key(b, 1'b0);
        else if (b != vkd_pkg::CH_TILDE)
            csi_kind = vkd_pkg::KEY_ESC;
        else if (len == vkd_pkg::CSI_LEN_W'(2))
        begin
            case (first_reg)
                vkd_pkg::CH_1: csi_kind = vkd_pkg::KEY_HOME;
                vkd_pkg::CH_3: csi_kind = vkd_pkg::KEY_DELETE;
                vkd_pkg::CH_4: csi_kind = vkd_pkg::KEY_END;
                vkd_pkg::CH_5: csi_kind = vkd_pkg::KEY_PGUP;
                vkd_pkg::CH_6: csi_kind = vkd_pkg::KEY_PGDN;
                default:       csi_kind = vkd_pkg::KEY_ESC;
            endcase
        end
        else if (len == vkd_pkg::CSI_LEN_W'(3) && first_reg == vkd_pkg::CH_1
                 && second_reg == vkd_pkg::CH_1)
            csi_kind = vkd_pkg::KEY_F1;
        else if (len == vkd_pkg::CSI_LEN_W'(3) && first_reg == vkd_pkg::CH_1
                 && second_reg == vkd_pkg::CH_5)
            csi_kind = vkd_pkg::KEY_F5;
        else
            csi_kind = vkd_pkg::KEY_ESC;

        mode_next       = mode_reg;
        wait_next       = wait_reg;
        len_next        = len_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        result.fire     = 1'b0;
        result.key.kind = vkd_pkg::KEY_PLAIN;
        result.key.code = 8'd0;

        if (step)
        begin
            if (item.operation == vkd_pkg::OP_TICK)
            begin
                wait_next = wait_inc;
                if (wait_inc >= limit)
                begin
                    wait_next       = 8'd0;
                    result.fire     = 1'b1;
                    result.key.kind = (mode_reg == MODE_IDLE) ? vkd_pkg::KEY_TIMEOUT
                                                              : vkd_pkg::KEY_ESC;
                    mode_next       = MODE_IDLE;
                end
            end
            else
            begin
                wait_next = 8'd0;
                case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (b == vkd_pkg::CH_ESC)
                            mode_next = MODE_ESC;
                        else if (b == vkd_pkg::CH_DEL)
                        begin
                            result.fire     = 1'b1;
                            result.key.kind = vkd_pkg::KEY_BACKSPACE;
                        end
                        else
                        begin
                            result.fire     = 1'b1;
                            result.key.code = b;
                        end
                    end
                    MODE_ESC:
                    begin
                        if (b == vkd_pkg::CH_CSI)
                        begin
                            mode_next = MODE_CSI;
                            len_next  = '0;
                        end
                        else if (b == vkd_pkg::CH_SS3)
                            mode_next = MODE_SS3;
                        else
                        begin
                            result.fire     = 1'b1;
                            result.key.kind = vkd_pkg::KEY_ESC;
                            mode_next       = MODE_IDLE;
                        end
                    end
                    MODE_SS3:
                    begin
                        result.fire     = 1'b1;
                        result.key.kind = vkd_pkg::letter_key(b, 1'b1);
                        mode_next       = MODE_IDLE;
                    end
                    default:
                    begin
                        if (is_final)
                        begin
                            result.fire     = 1'b1;
                            result.key.kind = csi_kind;
                            mode_next       = MODE_IDLE;
                        end
                        else
                        begin
                            if (len == vkd_pkg::CSI_LEN_W'(1))
                                first_next = b;
                            else if (len == vkd_pkg::CSI_LEN_W'(2))
                                second_next = b;
                            // overlong body gives up
                            if (len == vkd_pkg::CSI_LEN_W'(vkd_pkg::MAX_CSI_BYTES))
                            begin
                                result.fire     = 1'b1;
                                result.key.kind = vkd_pkg::KEY_ESC;
                                mode_next       = MODE_IDLE;
                            end
                            else
                                len_next = len;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            wait_reg   <= 8'd0;
            len_reg    <= '0;
            first_reg  <= 8'd0;
            second_reg <= 8'd0;
        end
        else
        begin
            mode_reg   <= mode_next;
            wait_reg   <= wait_next;
            len_reg    <= len_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/vkd_out_stage.sv -----
// vkd_out_stage: result register that holds a key word until the sink takes it
// depends on vkd_pkg
`default_nettype none

module vkd_out_stage
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire vkd_pkg::step_out_t result,
    output logic                    room,
    vkd_key_if.source               keys
);

    logic          valid_reg, valid_next;
    vkd_pkg::key_t key_reg, key_next;

    // free when empty or being drained this cycle
    assign room = !valid_reg || keys.ready;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (room)
        begin
            valid_next = load && result.fire;
            if (load && result.fire)
                key_next = result.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign keys.valid     = valid_reg;
    assign keys.key_kind  = key_reg.kind;
    assign keys.char_code = key_reg.code;

endmodule

`default_nettype wire

// ----- hdl/vt100_key_sequence_decoder.sv -----
// vt100_key_sequence_decoder: top level, input register, config registers, parser, output
// depends on vkd_pkg, vkd_channels, vkd_parser, vkd_out_stage
//
//   channel   dir   handshake     payload
//   feed      in    valid/ready   operation, byte_value
//   keys      out   valid/ready   key_kind, char_code
//   cfg       in    cfg_we        cfg_index, cfg_data (no ready)
//
// one word per cycle while the key output is not stalled; a word is registered,
// then decoded against the parser state into the output register when the output has room
// the rate is set by the single parser step between input and output registers
// reset clears the parser state, the valid flags and loads the wait defaults
// a stalled output holds its word; feed stays ready unless both registers are full and the output is stalled
`default_nettype none

module vt100_key_sequence_decoder
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    vkd_byte_if.sink                           feed,
    vkd_key_if.source                          keys,
    input  wire logic                          cfg_we,
    input  wire logic [vkd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data
);

    logic               in_valid_reg, in_valid_next;
    vkd_pkg::item_t     item_reg, item_next;
    logic [7:0]         esc_wait_reg, esc_wait_next;
    logic [7:0]         idle_wait_reg, idle_wait_next;
    logic               room;
    logic               step;
    vkd_pkg::step_out_t result;

    assign feed.ready = !in_valid_reg || room;
    assign step       = in_valid_reg && room;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (feed.ready)
        begin
            in_valid_next = feed.valid;
            if (feed.valid)
            begin
                item_next.operation  = feed.operation;
                item_next.byte_value = feed.byte_value;
            end
        end

        esc_wait_next  = esc_wait_reg;
        idle_wait_next = idle_wait_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                vkd_pkg::CFG_ESC_WAIT:  esc_wait_next  = cfg_data;
                vkd_pkg::CFG_IDLE_WAIT: idle_wait_next = cfg_data;
                default:                esc_wait_next  = esc_wait_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            esc_wait_reg  <= vkd_pkg::ESC_WAIT_RESET;
            idle_wait_reg <= vkd_pkg::IDLE_WAIT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            esc_wait_reg  <= esc_wait_next;
            idle_wait_reg <= idle_wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    vkd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item_reg),
        .esc_wait  (esc_wait_reg),
        .idle_wait (idle_wait_reg),
        .result    (result)
    );

    vkd_out_stage u_out
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (step),
        .result (result),
        .room   (room),
        .keys   (keys)
    );

endmodule

`default_nettype wire

// ----- hdl/vkd_checker.sv -----
// vkd_checker: port-level assertions on the key decoder, bound to the top level
// depends on vkd_pkg and vt100_key_sequence_decoder
`default_nettype none

module vkd_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [3:0] key_kind,
    input wire logic [7:0] char_code
);

    // a stalled key word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_kind) && $stable(char_code))
        else $error("key word changed while stalled");

    // feed only backs up behind a stalled output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("feed not ready without output stall");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_kind <= vkd_pkg::KEY_F5)
        else $error("key kind out of range");

    // only plain keys carry a byte
    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_kind != vkd_pkg::KEY_PLAIN |-> char_code == 8'd0)
        else $error("char code on a non-plain key");

endmodule

bind vt100_key_sequence_decoder vkd_checker u_vkd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (feed.ready),
    .out_valid (keys.valid),
    .out_ready (keys.ready),
    .key_kind  (keys.key_kind),
    .char_code (keys.char_code)
);

`default_nettype wire

// ----- verif/vt100_key_sequence_decoder_tb.sv -----
// vt100_key_sequence_decoder_tb: self-checking bench for the vt100 key decoder
// drives bytes and poll ticks, predicts the key events and checks them word by word
// depends on vkd_pkg, vkd_channels and the decoder rtl
`timescale 1ns / 100ps

module vt100_key_sequence_decoder_tb;

    typedef enum logic [1:0] {
        PM_IDLE = 2'd0,
        PM_ESC  = 2'd1,
        PM_SS3  = 2'd2,
        PM_CSI  = 2'd3
    } parse_mode_t;

    typedef struct {
        logic               op;
        logic [7:0]         b;
        logic               typed;
        vkd_pkg::key_kind_t kind;
        logic [7:0]         code;
    } dir_row_t;

    localparam int DIR_ROWS   = 26;
    localparam int WAIT_ROW   = 19;
    localparam int NUM_PHASES = 7;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [vkd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                    cfg_data;

    vkd_byte_if feed_if ();
    vkd_key_if  keys_if ();

    vt100_key_sequence_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .feed      (feed_if),
        .keys      (keys_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // decoder state mirror
    logic [7:0]  esc_limit  = vkd_pkg::ESC_WAIT_RESET;
    logic [7:0]  idle_limit = vkd_pkg::IDLE_WAIT_RESET;
    parse_mode_t pmode      = PM_IDLE;
    logic [7:0]  wait_cnt   = 8'd0;
    int unsigned csi_len    = 0;
    logic [7:0]  csi_b1     = 8'd0;
    logic [7:0]  csi_b2     = 8'd0;

    vkd_pkg::key_t pending_keys [$];

    int unsigned errors       = 0;
    int unsigned words_sent   = 0;
    int unsigned ticks_sent   = 0;
    int unsigned keys_checked = 0;
    int unsigned settings     = 0;
    logic        feed_burst   = 1'b0;
    logic        keys_burst   = 1'b0;

    logic [7:0] letters [7] = '{vkd_pkg::CH_A, vkd_pkg::CH_B, vkd_pkg::CH_C, vkd_pkg::CH_D,
                                vkd_pkg::CH_H, vkd_pkg::CH_F, vkd_pkg::CH_P};
    logic [7:0] digits  [5] = '{vkd_pkg::CH_1, vkd_pkg::CH_3, vkd_pkg::CH_4, vkd_pkg::CH_5,
                                vkd_pkg::CH_6};

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{vkd_pkg::OP_BYTE, 8'h00,             1'b1, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, 8'hFF,             1'b1, vkd_pkg::KEY_PLAIN,     8'hFF},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_DEL,   1'b1, vkd_pkg::KEY_BACKSPACE, 8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC,   1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_CSI,   1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_A,     1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC,   1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_SS3,   1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_P,     1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC,   1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_SS3,   1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, 8'h5A,             1'b1, vkd_pkg::KEY_ESC,       8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC,   1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_CSI,   1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_1,     1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_5,     1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_TILDE, 1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC,   1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, 8'h71,             1'b1, vkd_pkg::KEY_ESC,       8'h00},
        // waits of one tick from here on
        '{vkd_pkg::OP_TICK, 8'hFF,             1'b1, vkd_pkg::KEY_TIMEOUT,   8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC,   1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_TICK, 8'h00,             1'b1, vkd_pkg::KEY_ESC,       8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC,   1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_CSI,   1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_BYTE, vkd_pkg::CH_3,     1'b0, vkd_pkg::KEY_PLAIN,     8'h00},
        '{vkd_pkg::OP_TICK, 8'h00,             1'b1, vkd_pkg::KEY_ESC,       8'h00}
    };

    int phase_esc   [NUM_PHASES] = '{1, 10, 255, 0, 255, 1, -1};
    int phase_idle  [NUM_PHASES] = '{1, 40, 255, 0, 1, 255, -1};
    int phase_items [NUM_PHASES] = '{150, 200, 300, 100, 150, 150, 200};

    function automatic vkd_pkg::key_kind_t letter_kind(input logic [7:0] b,
                                                       input logic after_ss3);
        case (b)
            vkd_pkg::CH_A: return vkd_pkg::KEY_UP;
            vkd_pkg::CH_B: return vkd_pkg::KEY_DOWN;
            vkd_pkg::CH_C: return vkd_pkg::KEY_RIGHT;
            vkd_pkg::CH_D: return vkd_pkg::KEY_LEFT;
            vkd_pkg::CH_H: return vkd_pkg::KEY_HOME;
            vkd_pkg::CH_F: return vkd_pkg::KEY_END;
            vkd_pkg::CH_P: return after_ss3 ? vkd_pkg::KEY_F1 : vkd_pkg::KEY_ESC;
            default:       return vkd_pkg::KEY_ESC;
        endcase
    endfunction

    // len includes the final byte
    function automatic vkd_pkg::key_kind_t csi_kind(input int unsigned len,
                                                    input logic [7:0] fin);
        if (len == 1)
            return letter_kind(fin, 1'b0);
        if (fin != vkd_pkg::CH_TILDE)
            return vkd_pkg::KEY_ESC;
        if (len == 2)
        begin
            case (csi_b1)
                vkd_pkg::CH_1: return vkd_pkg::KEY_HOME;
                vkd_pkg::CH_3: return vkd_pkg::KEY_DELETE;
                vkd_pkg::CH_4: return vkd_pkg::KEY_END;
                vkd_pkg::CH_5: return vkd_pkg::KEY_PGUP;
                vkd_pkg::CH_6: return vkd_pkg::KEY_PGDN;
                default:       return vkd_pkg::KEY_ESC;
            endcase
        end
        if (len == 3 && csi_b1 == vkd_pkg::CH_1)
        begin
            if (csi_b2 == vkd_pkg::CH_1)
                return vkd_pkg::KEY_F1;
            if (csi_b2 == vkd_pkg::CH_5)
                return vkd_pkg::KEY_F5;
        end
        return vkd_pkg::KEY_ESC;
    endfunction

    // advances the mirror by one word; returns 1 when a key event comes out
    function automatic logic decode_word(input logic op, input logic [7:0] b,
                                         output vkd_pkg::key_t key);
        logic [7:0]  limit;
        int unsigned len;
        key.kind = vkd_pkg::KEY_PLAIN;
        key.code = 8'd0;
        if (op == vkd_pkg::OP_TICK)
        begin
            limit = (pmode == PM_IDLE) ? idle_limit : esc_limit;
            if (wait_cnt != 8'hFF)
                wait_cnt = wait_cnt + 8'd1;
            if (wait_cnt < limit)
                return 1'b0;
            wait_cnt = 8'd0;
            key.kind = (pmode == PM_IDLE) ? vkd_pkg::KEY_TIMEOUT : vkd_pkg::KEY_ESC;
            pmode = PM_IDLE;
            return 1'b1;
        end
        wait_cnt = 8'd0;
        case (pmode)
            PM_IDLE:
            begin
                if (b == vkd_pkg::CH_ESC)
                begin
                    pmode = PM_ESC;
                    return 1'b0;
                end
                if (b == vkd_pkg::CH_DEL)
                    key.kind = vkd_pkg::KEY_BACKSPACE;
                else
                    key.code = b;
            end
            PM_ESC:
            begin
                if (b == vkd_pkg::CH_CSI)
                begin
                    pmode = PM_CSI;
                    csi_len = 0;
                    return 1'b0;
                end
                if (b == vkd_pkg::CH_SS3)
                begin
                    pmode = PM_SS3;
                    return 1'b0;
                end
                key.kind = vkd_pkg::KEY_ESC;
                pmode = PM_IDLE;
            end
            PM_SS3:
            begin
                key.kind = letter_kind(b, 1'b1);
                pmode = PM_IDLE;
            end
            default:
            begin
                len = csi_len + 1;
                if (b >= vkd_pkg::CH_FINAL_LO && b <= vkd_pkg::CH_FINAL_HI)
                begin
                    key.kind = csi_kind(len, b);
                    pmode = PM_IDLE;
                end
                else
                begin
                    if (len == 1)
                        csi_b1 = b;
                    else if (len == 2)
                        csi_b2 = b;
                    // overlong body gives up with ESC
                    if (len >= vkd_pkg::MAX_CSI_BYTES)
                    begin
                        key.kind = vkd_pkg::KEY_ESC;
                        pmode = PM_IDLE;
                    end
                    else
                    begin
                        csi_len = len;
                        return 1'b0;
                    end
                end
            end
        endcase
        return 1'b1;
    endfunction

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic send_word(input logic op, input logic [7:0] b,
                             output logic fire, output vkd_pkg::key_t key);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0)
            feed_burst = ~feed_burst;
        gap = feed_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            feed_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        feed_if.valid      <= 1'b1;
        feed_if.operation  <= op;
        feed_if.byte_value <= b;
        do
            @(posedge clk);
        while (feed_if.ready !== 1'b1);
        fire = decode_word(op, b, key);
        words_sent++;
        if (op == vkd_pkg::OP_TICK)
            ticks_sent++;
    endtask

    task automatic push_word(input logic op, input logic [7:0] b);
        logic          fire;
        vkd_pkg::key_t key;
        send_word(op, b, fire, key);
        if (fire)
            pending_keys.push_back(key);
    endtask

    task automatic tick_run(input int n);
        repeat (n) push_word(vkd_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    // sender holds off until every key has come and the pipeline is empty
    task automatic drain_keys();
        feed_if.valid <= 1'b0;
        while (pending_keys.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [7:0] esc_v, input logic [7:0] idle_v);
        cfg_we    <= 1'b1;
        cfg_index <= vkd_pkg::CFG_ESC_WAIT;
        cfg_data  <= esc_v;
        @(posedge clk);
        cfg_index <= vkd_pkg::CFG_IDLE_WAIT;
        cfg_data  <= idle_v;
        @(posedge clk);
        cfg_we <= 1'b0;
        esc_limit  = esc_v;
        idle_limit = idle_v;
        settings++;
    endtask

    function automatic logic [7:0] body_byte();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 8'h3F));
        return 8'($urandom_range(8'h7F, 8'hFF));
    endfunction

    function automatic logic [7:0] final_byte();
        return 8'($urandom_range(vkd_pkg::CH_FINAL_LO, vkd_pkg::CH_FINAL_HI));
    endfunction

    function automatic int ticks_to_limit();
        logic [7:0] limit;
        limit = (pmode == PM_IDLE) ? idle_limit : esc_limit;
        return (limit > wait_cnt) ? int'(limit - wait_cnt) : 1;
    endfunction

    // mostly well-formed key sequences with random content, some noise
    task automatic send_sequence();
        int unsigned sel;
        int          n;
        sel = $urandom_range(0, 15);
        case (sel)
            0, 1, 2:
                push_word(vkd_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            3:
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_DEL);
            4, 5:
            begin
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC);
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_CSI);
                push_word(vkd_pkg::OP_BYTE, ($urandom_range(0, 3) != 0) ?
                          letters[$urandom_range(0, 6)] : final_byte());
            end
            6, 7:
            begin
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC);
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_CSI);
                push_word(vkd_pkg::OP_BYTE, ($urandom_range(0, 3) != 0) ?
                          digits[$urandom_range(0, 4)] : body_byte());
                push_word(vkd_pkg::OP_BYTE, ($urandom_range(0, 3) != 0) ?
                          vkd_pkg::CH_TILDE : final_byte());
            end
            8:
            begin
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC);
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_CSI);
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_1);
                case ($urandom_range(0, 2))
                    0:       push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_1);
                    1:       push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_5);
                    default: push_word(vkd_pkg::OP_BYTE, body_byte());
                endcase
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_TILDE);
            end
            9:
            begin
                // random body length, past the csi limit at times
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC);
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_CSI);
                n = $urandom_range(0, vkd_pkg::MAX_CSI_BYTES + 1);
                repeat (n) push_word(vkd_pkg::OP_BYTE, body_byte());
                push_word(vkd_pkg::OP_BYTE, final_byte());
            end
            10, 11:
            begin
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC);
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_SS3);
                push_word(vkd_pkg::OP_BYTE, ($urandom_range(0, 3) != 0) ?
                          letters[$urandom_range(0, 6)] : 8'($urandom_range(0, 255)));
            end
            12:
            begin
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC);
                push_word(vkd_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            end
            13:
                tick_run($urandom_range(1, 3));
            14:
            begin
                n = ticks_to_limit() + int'($urandom_range(0, 2)) - 1;
                tick_run((n < 1) ? 1 : n);
            end
            default:
            begin
                // sequence left hanging, then timed out or broken by a byte
                push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_ESC);
                case ($urandom_range(0, 3))
                    0:       ;
                    1:       push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_SS3);
                    2:       push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_CSI);
                    default:
                    begin
                        push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_CSI);
                        push_word(vkd_pkg::OP_BYTE, vkd_pkg::CH_1);
                    end
                endcase
                if ($urandom_range(0, 2) != 0)
                    tick_run(ticks_to_limit());
                else
                    push_word(vkd_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // key sink with random stalls
    initial
    begin : key_sink
        vkd_pkg::key_t want;
        int unsigned   stall;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                keys_burst = ~keys_burst;
            stall = keys_burst ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                keys_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            keys_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (keys_if.valid !== 1'b1);
            keys_checked++;
            if (pending_keys.size() == 0)
            begin
                report($sformatf("unexpected key kind %0d code %02h",
                                 keys_if.key_kind, keys_if.char_code));
            end
            else
            begin
                want = pending_keys.pop_front();
                if (keys_if.key_kind !== want.kind)
                    report($sformatf("key_kind %0d, expected %0d (%s)",
                                     keys_if.key_kind, want.kind, want.kind.name()));
                if (keys_if.char_code !== want.code)
                    report($sformatf("char_code %02h, expected %02h",
                                     keys_if.char_code, want.code));
            end
        end
    end

    initial
    begin
        logic          fire;
        vkd_pkg::key_t got;
        vkd_pkg::key_t want;
        int unsigned   target;
        logic [7:0]    esc_v;
        logic [7:0]    idle_v;
        logic          paused;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = vkd_pkg::CFG_ESC_WAIT;
        cfg_data           = 8'd0;
        feed_if.valid      = 1'b0;
        feed_if.operation  = vkd_pkg::OP_BYTE;
        feed_if.byte_value = 8'd0;
        keys_if.ready      = 1'b0;
        paused             = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i == WAIT_ROW)
            begin
                drain_keys();
                write_cfg(8'd1, 8'd1);
            end
            send_word(dir_rows[i].op, dir_rows[i].b, fire, got);
            if (dir_rows[i].typed)
            begin
                want.kind = dir_rows[i].kind;
                want.code = dir_rows[i].code;
                if (!fire || got != want)
                    report($sformatf("prediction differs from table on row %0d", i));
                pending_keys.push_back(want);
            end
            else if (fire)
            begin
                pending_keys.push_back(got);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p != 0)
            begin
                drain_keys();
                esc_v  = (phase_esc[p] < 0) ? 8'($urandom_range(2, 30)) : 8'(phase_esc[p]);
                idle_v = (phase_idle[p] < 0) ? 8'($urandom_range(2, 60)) : 8'(phase_idle[p]);
                write_cfg(esc_v, idle_v);
            end
            target = words_sent + phase_items[p];
            while (words_sent < target)
            begin
                send_sequence();
                if (p == 1 && !paused && words_sent >= target - phase_items[p] / 2)
                begin
                    drain_keys();
                    paused = 1'b1;
                end
            end
        end

        drain_keys();
        $display("covered %0d words (%0d poll ticks), %0d keys checked", words_sent,
                 ticks_sent, keys_checked);
        $display("over %0d wait settings from 0 to 255, csi bodies up to past %0d bytes",
                 settings, vkd_pkg::MAX_CSI_BYTES);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/vkd_pkg.sv
hdl/vkd_channels.sv
hdl/vkd_parser.sv
hdl/vkd_out_stage.sv
hdl/vt100_key_sequence_decoder.sv
hdl/vkd_checker.sv
verif/vt100_key_sequence_decoder_tb.sv
